@@ hw/rtl/assert_macros.svh @@
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication assertion with active-low reset disable.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hw/rtl/cwf_pkg.sv @@
// ----------------------------------------------------------------------------
// cwf_pkg
// Shared types and constants for the window filter.
// ----------------------------------------------------------------------------
package cwf_pkg;
    localparam int unsigned PIX_W   = 24;
    localparam int unsigned SAMP_W  = 8;
    localparam int unsigned COEF_W  = 12;
    localparam int unsigned ROW_W   = 60;
    localparam int unsigned NUM_CH  = 3;
    localparam int unsigned REG_IDX_W = 3;
    localparam int unsigned DATA_W  = 64;

    localparam logic [REG_IDX_W-1:0] REG_COEFF0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEFF1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEFF2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEFF3 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEFF4 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_MODE   = 3'd7;

    typedef struct packed {
        logic [SAMP_W-1:0] sample_0;
        logic [SAMP_W-1:0] sample_1;
        logic [SAMP_W-1:0] sample_2;
    } t_in_item;

    typedef struct packed {
        logic [SAMP_W-1:0] result_0;
        logic [SAMP_W-1:0] result_1;
        logic [SAMP_W-1:0] result_2;
        logic              row_end;
        logic              frame_end;
    } t_out_item;

    typedef struct packed {
        logic [3:0]        index;
        logic [DATA_W-1:0] data;
    } t_cfg_item;

    // Tags that travel with a window through the lane pipeline.
    typedef struct packed {
        logic valid;
        logic color;
        logic row_end;
        logic frame_end;
    } t_tag;
endpackage

@@ hw/rtl/cwf_if.sv @@
// ----------------------------------------------------------------------------
// cwf_if
// Valid/ready stream channel with source and sink views.
// ----------------------------------------------------------------------------
interface cwf_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/conv2d_window_filter.sv @@
// ----------------------------------------------------------------------------
// conv2d_window_filter
// KxK window filter over a raster stream, one lane per color channel.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload                                   | Accept
// s_in    | in  | sample_0..2                               | valid & ready
// m_out   | out | result_0..2, row_end, frame_end           | valid & ready
// s_cfg   | in  | index (4b), data (64b)                    | valid & ready
//
// One pixel per cycle sustained while the output is not stalled; a result leaves
// through the line RAM read, window shift, lane product, lane sum and round stages.
// The pipeline advances as a whole when the output slot is empty or taken.
// Synchronous active-low reset clears control state and the window.
// Line RAMs are not cleared: each entry is written during the first K-1 rows of a
// frame before a window that uses it becomes a result.
// ----------------------------------------------------------------------------
module conv2d_window_filter #(
    parameter int unsigned KERNEL_SIZE     = 3,
    parameter int unsigned MAX_LINE        = 2048,
    parameter int unsigned COEFF_FRAC_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cwf_if.sink   s_in,
    cwf_if.source m_out,
    cwf_if.sink   s_cfg
);
    import cwf_pkg::*;

    localparam int unsigned K     = KERNEL_SIZE;
    localparam int unsigned AW    = $clog2(MAX_LINE);
    localparam int unsigned CW    = AW + 1;
    localparam int unsigned ACC_W = 26;
    localparam int unsigned LR    = (K > 1) ? K - 1 : 1;

    // Configuration registers
    logic [ROW_W-1:0] r_coef [5];
    logic [11:0]      r_width;
    logic [15:0]      r_height;
    logic             r_mode;

    // Effective sizes
    logic [CW-1:0] eff_w;
    logic [15:0]   eff_h;
    always_comb begin
        if (r_width == '0) begin
            eff_w = CW'(1);
        end else if (32'(r_width) > MAX_LINE) begin
            eff_w = CW'(MAX_LINE);
        end else begin
            eff_w = CW'(r_width);
        end
        eff_h = (r_height == '0) ? 16'd1 : r_height;
    end

    // Pipeline control: everything moves on adv
    logic r_ovalid;
    logic adv;
    assign adv       = !r_ovalid || m_out.ready;
    assign s_in.ready = adv;
    assign s_cfg.ready = 1'b1;
    logic acc;
    assign acc = s_in.valid && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 5; r++) begin
                r_coef[r] <= '0;
            end
            r_width  <= 12'd2048;
            r_height <= 16'hFFFF;
            r_mode   <= 1'b0;
        end else if (s_cfg.valid) begin
            case (s_cfg.data.index)
                4'(REG_COEFF0): r_coef[0] <= s_cfg.data.data[ROW_W-1:0];
                4'(REG_COEFF1): r_coef[1] <= s_cfg.data.data[ROW_W-1:0];
                4'(REG_COEFF2): r_coef[2] <= s_cfg.data.data[ROW_W-1:0];
                4'(REG_COEFF3): r_coef[3] <= s_cfg.data.data[ROW_W-1:0];
                4'(REG_COEFF4): r_coef[4] <= s_cfg.data.data[ROW_W-1:0];
                4'(REG_WIDTH):  r_width   <= s_cfg.data.data[11:0];
                4'(REG_HEIGHT): r_height  <= s_cfg.data.data[15:0];
                4'(REG_MODE):   r_mode    <= s_cfg.data.data[0];
                default: ;
            endcase
        end
    end

    logic size_wr;
    assign size_wr = s_cfg.valid && (s_cfg.data.index == 4'(REG_WIDTH)
                                  || s_cfg.data.index == 4'(REG_HEIGHT));

    // Stage 0: position tracking, RAM read issue
    logic [CW-1:0] r_col;
    logic [15:0]   r_row;
    logic last_col, last_row, win_ok;
    assign last_col = r_col >= eff_w - CW'(1);
    assign last_row = r_row >= eff_h - 16'd1;
    assign win_ok   = (32'(r_col) >= K - 1) && (32'(r_row) >= K - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || size_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? 16'd0 : r_row + 16'd1;
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    logic [AW-1:0] cpos;
    assign cpos = r_col[AW-1:0];

    logic [PIX_W-1:0] pix;
    assign pix = {r_mode ? s_in.data.sample_2 : 8'd0,
                  r_mode ? s_in.data.sample_1 : 8'd0,
                  s_in.data.sample_0};

    // Stage 1 registers
    logic             r1_v;
    logic [PIX_W-1:0] r1_pix;
    logic [AW-1:0]    r1_addr;
    t_tag             r1_tag;
    logic [PIX_W-1:0] ram_q [LR];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv) begin
            r1_v <= acc;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_pix  <= pix;
            r1_addr <= cpos;
            r1_tag  <= '{valid: acc && win_ok, color: r_mode,
                         row_end: last_col, frame_end: last_col && last_row};
        end
    end

    // Column vector: oldest row first, current pixel last
    logic [PIX_W-1:0] col [K];
    always_comb begin
        for (int r = 0; r < K - 1; r++) begin
            col[r] = ram_q[r];
        end
        col[K-1] = r1_pix;
    end

    // Line RAMs: row r stores col[r+1] at the same column
    for (genvar g = 0; g < LR; g++) begin : g_line
        if (K > 1) begin : g_on
            cwf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE)) u_ram (
                .i_clk  (i_clk),
                .i_we   (adv && r1_v),
                .i_waddr(r1_addr),
                .i_wdata(col[g+1]),
                .i_re   (adv),
                .i_raddr(cpos),
                .o_rdata(ram_q[g])
            );
        end else begin : g_off
            assign ram_q[g] = '0;
        end
    end

    // Read-after-write: the stage 0 read misses the stage 1 write only when
    // both hit the same column, which needs a width of 1. Such a frame never
    // yields a result, and the next frame rewrites those entries before use.

    // Stage 2: window shift register
    logic [PIX_W-1:0] r_win [K][K];
    t_tag             r2_tag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < K; r++) begin
                for (int c = 0; c < K; c++) begin
                    r_win[r][c] <= '0;
                end
            end
            r2_tag <= '0;
        end else if (adv) begin
            r2_tag <= r1_v ? r1_tag : '0;
            if (r1_v) begin
                for (int r = 0; r < K; r++) begin
                    for (int c = 0; c < K - 1; c++) begin
                        r_win[r][c] <= r_win[r][c+1];
                    end
                    r_win[r][K-1] <= col[r];
                end
            end
        end
    end

    // Lanes: one per channel
    logic [K*K*COEF_W-1:0] coefs;
    always_comb begin
        for (int r = 0; r < K; r++) begin
            for (int c = 0; c < K; c++) begin
                coefs[(r*K+c)*COEF_W +: COEF_W] = r_coef[r][c*COEF_W +: COEF_W];
            end
        end
    end

    logic [NUM_CH*ACC_W-1:0] sums;
    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
        logic [K*K*SAMP_W-1:0] px;
        always_comb begin
            for (int r = 0; r < K; r++) begin
                for (int c = 0; c < K; c++) begin
                    px[(r*K+c)*SAMP_W +: SAMP_W] = r_win[r][c][ch*SAMP_W +: SAMP_W];
                end
            end
        end
        cwf_lane #(.K(K), .ACC_W(ACC_W)) u_lane (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_px  (px),
            .i_coef(coefs),
            .o_sum (sums[ch*ACC_W +: ACC_W])
        );
    end

    // Tag delay to match the two lane stages
    t_tag r3_tag, r4_tag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_tag <= '0;
            r4_tag <= '0;
        end else if (adv) begin
            r3_tag <= r2_tag;
            r4_tag <= r3_tag;
        end
    end

    t_out_item item;
    cwf_merge #(.FRAC(COEFF_FRAC_BITS), .ACC_W(ACC_W)) u_merge (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_sums(sums),
        .i_tag (r4_tag),
        .o_item(item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_ovalid <= r4_tag.valid;
        end
    end

    assign m_out.valid = r_ovalid;
    assign m_out.data  = item;
endmodule

@@ hw/rtl/cwf_ram.sv @@
// ----------------------------------------------------------------------------
// cwf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cwf_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end
    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/cwf_lane.sv @@
// ----------------------------------------------------------------------------
// cwf_lane
// One channel lane: KxK products, registered, then summed and registered.
// ----------------------------------------------------------------------------
module cwf_lane #(
    parameter int unsigned K = 3,
    parameter int unsigned ACC_W = 26
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [K*K*cwf_pkg::SAMP_W-1:0] i_px,
    input  logic [K*K*cwf_pkg::COEF_W-1:0] i_coef,
    output logic signed [ACC_W-1:0]        o_sum
);
    import cwf_pkg::*;
    localparam int unsigned PROD_W = COEF_W + SAMP_W + 1;

    logic signed [PROD_W-1:0] r_prod [K*K];
    logic signed [ACC_W-1:0]  r_sum;
    logic signed [ACC_W-1:0]  n_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < K*K; i++) begin
                r_prod[i] <= $signed({1'b0, i_px[i*SAMP_W +: SAMP_W]})
                           * $signed(i_coef[i*COEF_W +: COEF_W]);
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < K*K; i++) begin
            n_sum = n_sum + ACC_W'(r_prod[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end
    assign o_sum = r_sum;
endmodule

@@ hw/rtl/cwf_merge.sv @@
// ----------------------------------------------------------------------------
// cwf_merge
// Rounds each lane sum (nearest, ties to even), saturates and packs the item.
// ----------------------------------------------------------------------------
module cwf_merge #(
    parameter int unsigned FRAC  = 8,
    parameter int unsigned ACC_W = 26
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [cwf_pkg::NUM_CH*ACC_W-1:0] i_sums,
    input  cwf_pkg::t_tag                      i_tag,
    output cwf_pkg::t_out_item                 o_item
);
    import cwf_pkg::*;

    logic [SAMP_W-1:0] n_res [NUM_CH];
    t_out_item         r_item;

    function automatic logic [SAMP_W-1:0] round_sat(input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0] q;
        logic [FRAC-1:0]         rem;
        logic                    up;
        logic signed [ACC_W-1:0] v;
        q   = s >>> FRAC;
        rem = s[FRAC-1:0];
        up  = (rem > (FRAC)'(1 << (FRAC-1)))
           || ((rem == (FRAC)'(1 << (FRAC-1))) && q[0]);
        v   = q + ACC_W'(up);
        if (v < 0) begin
            return '0;
        end else if (v > 255) begin
            return '1;
        end
        return v[SAMP_W-1:0];
    endfunction

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_res[c] = round_sat(i_sums[c*ACC_W +: ACC_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item.result_0  <= n_res[0];
            r_item.result_1  <= i_tag.color ? n_res[1] : '0;
            r_item.result_2  <= i_tag.color ? n_res[2] : '0;
            r_item.row_end   <= i_tag.row_end;
            r_item.frame_end <= i_tag.frame_end;
        end
    end
    assign o_item = r_item;
endmodule

@@ hw/rtl/cwf_checker.sv @@
// ----------------------------------------------------------------------------
// cwf_checker
// Port-level checks of the window filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cwf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input cwf_pkg::t_out_item i_out_data,
    input logic               i_in_ready
);
    `CHK_IMPL(a_frame_row, i_clk, i_rst_n, i_out_valid && i_out_data.frame_end, i_out_data.row_end, "frame_end without row_end")
    `CHK_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "output changed while stalled")
    `CHK_IMPL(a_stall, i_clk, i_rst_n, i_out_valid && !i_out_ready, !i_in_ready, "input taken while output stalled")
endmodule

bind conv2d_window_filter cwf_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(m_out.valid),
    .i_out_ready(m_out.ready),
    .i_out_data (m_out.data),
    .i_in_ready (s_in.ready)
);
